// ===== hdl/caf_pkg.sv =====
// caf_pkg: shared types, constants and the cordic angle table for the
// complementary attitude filter. No dependencies.
`default_nettype none
package caf_pkg;

    localparam int ATAN_DEPTH = 24;
    localparam logic signed [25:0] DEG90_Q16 = 26'sd5898240;
    localparam logic signed [17:0] ANGLE_LIMIT = 18'sd92160;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_ROLL_PRE,
        ST_ROLL_ITER,
        ST_PITCH_PRE,
        ST_PITCH_ITER,
        ST_FUSE_ROLL,
        ST_FUSE_PITCH,
        ST_OUT
    } caf_state_t;

    typedef struct packed {
        logic load;        // capture input item
        logic sqrt_step;   // one root digit
        logic cordic_init; // load cordic operands and apply quadrant fix
        logic cordic_sel;  // 0 roll operands, 1 pitch operands
        logic cordic_step; // one micro-rotation
        logic save_roll;   // keep cordic angle as roll
        logic fuse_step;   // advance the fuse pipeline one step
        logic fuse_sel;    // 0 roll, 1 pitch
        logic commit;      // write estimates and output register
    } caf_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
        logic fuse_done;
    } caf_status_t;

    function automatic logic [25:0] atan_entry(input logic [4:0] idx);
        logic [25:0] v;
        begin
            unique case (idx)
                5'd0:  v = 26'd2949120;
                5'd1:  v = 26'd1740967;
                5'd2:  v = 26'd919879;
                5'd3:  v = 26'd466945;
                5'd4:  v = 26'd234379;
                5'd5:  v = 26'd117304;
                5'd6:  v = 26'd58666;
                5'd7:  v = 26'd29335;
                5'd8:  v = 26'd14668;
                5'd9:  v = 26'd7334;
                5'd10: v = 26'd3667;
                5'd11: v = 26'd1833;
                5'd12: v = 26'd917;
                5'd13: v = 26'd458;
                5'd14: v = 26'd229;
                5'd15: v = 26'd115;
                5'd16: v = 26'd57;
                5'd17: v = 26'd29;
                5'd18: v = 26'd14;
                5'd19: v = 26'd7;
                5'd20: v = 26'd4;
                5'd21: v = 26'd2;
                5'd22: v = 26'd1;
                default: v = 26'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/caf_ctrl.sv =====
// caf_ctrl: sequencer for the attitude filter datapath.
// Depends on caf_pkg for the state enum and command/status structs.
`default_nettype none
module caf_ctrl
    import caf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output caf_cmd_t         cmd,
    input  wire caf_status_t status
);

    caf_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done) begin
                    state_next = ST_ROLL_PRE;
                end
            end
            ST_ROLL_PRE: begin
                cmd.cordic_init = 1'b1;
                state_next      = ST_ROLL_ITER;
            end
            ST_ROLL_ITER: begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_done) begin
                    cmd.save_roll = 1'b1;
                    state_next    = ST_PITCH_PRE;
                end
            end
            ST_PITCH_PRE: begin
                cmd.cordic_init = 1'b1;
                cmd.cordic_sel  = 1'b1;
                state_next      = ST_PITCH_ITER;
            end
            ST_PITCH_ITER: begin
                cmd.cordic_sel  = 1'b1;
                cmd.cordic_step = 1'b1;
                if (status.cordic_done) begin
                    state_next = ST_FUSE_ROLL;
                end
            end
            ST_FUSE_ROLL: begin
                cmd.fuse_step = 1'b1;
                if (status.fuse_done) begin
                    state_next = ST_FUSE_PITCH;
                end
            end
            ST_FUSE_PITCH: begin
                cmd.fuse_step = 1'b1;
                cmd.fuse_sel  = 1'b1;
                if (status.fuse_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/caf_datapath.sv =====
// caf_datapath: root unit, shared cordic, blend arithmetic and state regs.
// Depends on caf_pkg; driven by caf_ctrl commands.
`default_nettype none
module caf_datapath
    import caf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] gyro_roll_rate,
    input  wire logic signed [15:0] gyro_pitch_rate,
    input  wire logic        [15:0] elapsed_time,
    input  wire logic               cfg_wr_en,
    input  wire logic        [15:0] cfg_wr_data,
    input  wire caf_cmd_t           cmd,
    output caf_status_t             status,
    output logic signed      [17:0] roll_angle,
    output logic signed      [17:0] pitch_angle
);

    localparam int IW = $clog2(CORDIC_ITERATIONS + 1);
    // cordic working width: |operand| < 2^25, growth bounded below 2^27
    localparam int CW = 28;

    logic [15:0]        alpha_reg;
    logic signed [15:0] ax_reg, gr_reg, gp_reg;
    logic signed [15:0] ay_reg, az_reg;
    logic [15:0]        dt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= 16'd64225;
        end else if (cfg_wr_en) begin
            alpha_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gr_reg <= gyro_roll_rate;
            gp_reg <= gyro_pitch_rate;
            dt_reg <= elapsed_time;
        end
    end

    // root: sqrt((ay^2+az^2)*65536) = 256*sqrt(ay^2+az^2) floored
    // radicand <= 2^47, root < 2^24, one bit per cycle
    logic [47:0] rad_reg;
    logic [23:0] root_reg;
    logic [25:0] rem_reg;
    logic [4:0]  sq_cnt_reg;
    logic [31:0] ay_sq, az_sq;
    logic [25:0] rem_sh, trial;

    assign ay_sq = 32'($signed(ay_reg) * $signed(ay_reg));
    assign az_sq = 32'($signed(az_reg) * $signed(az_reg));
    assign rem_sh = {rem_reg[23:0], rad_reg[47:46]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sq_cnt_reg <= '0;
            root_reg   <= '0;
            rem_reg    <= '0;
            rad_reg    <= '0;
        end else if (cmd.sqrt_step) begin
            if (sq_cnt_reg == 5'd0) begin
                // first cycle just loads the radicand
                rad_reg    <= {ay_sq + az_sq, 16'd0};
                sq_cnt_reg <= 5'd1;
            end else begin
                rad_reg    <= {rad_reg[45:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
        end
    end
    assign status.sqrt_done = (sq_cnt_reg == 5'd24);

    // cordic, vectoring mode
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [26:0]   cz_reg;
    logic [IW-1:0]        it_reg;
    logic signed [CW-1:0] x0, y0, dx, dy;
    logic signed [26:0]   roll_ang_reg;
    logic [4:0]           it_idx;

    always_comb begin
        if (cmd.cordic_sel) begin
            x0 = CW'($signed({1'b0, root_reg}));
            y0 = -(CW'($signed(ax_reg)) <<< 8);
        end else begin
            x0 = CW'($signed(az_reg)) <<< 8;
            y0 = CW'($signed(ay_reg)) <<< 8;
        end
        dx = cy_reg >>> it_reg;
        dy = cx_reg >>> it_reg;
        it_idx = 5'(it_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cordic_init) begin
            it_reg <= '0;
            if (x0 < 0) begin
                if (y0 >= 0) begin
                    cx_reg <= y0;
                    cy_reg <= -x0;
                    cz_reg <= 27'(DEG90_Q16);
                end else begin
                    cx_reg <= -y0;
                    cy_reg <= x0;
                    cz_reg <= -27'(DEG90_Q16);
                end
            end else begin
                cx_reg <= x0;
                cy_reg <= y0;
                cz_reg <= '0;
            end
        end else if (cmd.cordic_step && !status.cordic_done) begin
            it_reg <= it_reg + 1'b1;
            if (cy_reg >= 0) begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + 27'($signed({1'b0, atan_entry(it_idx)}));
            end else begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - 27'($signed({1'b0, atan_entry(it_idx)}));
            end
        end
    end
    assign status.cordic_done = (it_reg == IW'(CORDIC_ITERATIONS));

    // zero vector gives zero angle; the rotations alone would not
    always_ff @(posedge aclk) begin
        if (cmd.save_roll) begin
            roll_ang_reg <= cz_reg;
        end
    end

    logic roll_zero, pitch_zero;
    assign roll_zero  = (ay_reg == 16'sd0) && (az_reg == 16'sd0);
    assign pitch_zero = (ax_reg == 16'sd0) && (root_reg == 24'd0);

    // fuse: step 0 products, step 1 blend products, step 2 round and clamp
    logic signed [17:0] roll_est_reg, pitch_est_reg;
    logic signed [17:0] roll_new_reg, pitch_new_reg;
    logic [1:0]         fs_reg;
    logic signed [42:0] gyro_reg;
    logic signed [34:0] acc_reg;
    logic signed [59:0] mg_reg, ma_reg;
    logic signed [17:0] est_sel;
    logic signed [15:0] rate_sel;
    logic signed [26:0] ang_sel;
    logic signed [60:0] mix;
    logic signed [28:0] rnd;
    logic signed [17:0] sat;

    always_comb begin
        est_sel  = cmd.fuse_sel ? pitch_est_reg : roll_est_reg;
        rate_sel = cmd.fuse_sel ? gp_reg : gr_reg;
        if (cmd.fuse_sel) begin
            ang_sel = pitch_zero ? 27'sd0 : cz_reg;
        end else begin
            ang_sel = roll_zero ? 27'sd0 : roll_ang_reg;
        end
        mix = 61'(mg_reg) + 61'(ma_reg) + 61'sd2147483648;
        rnd = 29'(mix >>> 32);
        if (rnd > 29'(ANGLE_LIMIT)) begin
            sat = ANGLE_LIMIT;
        end else if (rnd < -29'(ANGLE_LIMIT)) begin
            sat = -ANGLE_LIMIT;
        end else begin
            sat = 18'(rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fs_reg <= '0;
        end else if (cmd.fuse_step) begin
            fs_reg <= (fs_reg == 2'd2) ? 2'd0 : fs_reg + 2'd1;
            unique case (fs_reg)
                2'd0: begin
                    gyro_reg <= (43'(est_sel) <<< 16)
                              + 43'($signed(rate_sel) * $signed({1'b0, dt_reg}));
                    acc_reg  <= 35'(ang_sel) <<< 8;
                end
                2'd1: begin
                    mg_reg <= 60'($signed({1'b0, alpha_reg}) * gyro_reg);
                    ma_reg <= 60'($signed({1'b0, 17'd65536 - {1'b0, alpha_reg}})
                              * acc_reg);
                end
                default: begin
                    if (cmd.fuse_sel) pitch_new_reg <= sat;
                    else              roll_new_reg  <= sat;
                end
            endcase
        end
    end
    assign status.fuse_done = (fs_reg == 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_est_reg  <= '0;
            pitch_est_reg <= '0;
        end else if (cmd.commit) begin
            roll_est_reg  <= roll_new_reg;
            pitch_est_reg <= pitch_new_reg;
        end
    end

    assign roll_angle  = roll_est_reg;
    assign pitch_angle = pitch_est_reg;

endmodule
`default_nettype wire

// ===== hdl/complementary_attitude_filter.sv =====
// Complementary roll/pitch attitude filter.
// Input stream s_axis: one imu sample per item, tdata packs accel_x, accel_y,
// accel_z, gyro_roll_rate, gyro_pitch_rate, elapsed_time (lowest first).
// Output stream m_axis: one item per sample, roll_angle then pitch_angle,
// in 1/256 degree, clamped to +-360 degree.
// cfg_wr_en/cfg_wr_data write the 16-bit gyro weight alpha (Q0.16), reset
// 64225; write only while no sample is in flight.
// An item passes from acceptance to output through the bit-serial square
// root, two passes of the shared cordic (roll, then pitch), the blend unit
// for each angle in turn and a commit. One item is processed at a time: the
// next is taken only once the current one is committed, and
// s_axis_tready is high only while the unit is idle.
// The result sits in an output register; a stalled receiver holds it and
// the next item may be taken and worked on meanwhile, waiting only at commit.
// Reset (aresetn low, synchronous) clears both estimates to zero, restores
// alpha and drops any pending item.
`default_nettype none
module complementary_attitude_filter
    import caf_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_roll_rate, gyro_pitch_rate, elapsed_time
    input  wire logic [95:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // roll_angle, pitch_angle, zero fill
    output logic [39:0]       m_axis_tdata,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data
);

    caf_cmd_t           cmd;
    caf_status_t        status;
    logic signed [17:0] roll_angle, pitch_angle;
    logic               in_ready_w, out_valid_w;

    caf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (in_ready_w),
        .out_valid (out_valid_w),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    caf_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accel_x         (s_axis_tdata[15:0]),
        .accel_y         (s_axis_tdata[31:16]),
        .accel_z         (s_axis_tdata[47:32]),
        .gyro_roll_rate  (s_axis_tdata[63:48]),
        .gyro_pitch_rate (s_axis_tdata[79:64]),
        .elapsed_time    (s_axis_tdata[95:80]),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .roll_angle      (roll_angle),
        .pitch_angle     (pitch_angle)
    );

    assign s_axis_tready = in_ready_w;
    assign m_axis_tvalid = out_valid_w;
    assign m_axis_tdata  = {4'd0, pitch_angle, roll_angle};

endmodule
`default_nettype wire

// ===== hdl/caf_checker.sv =====
// caf_checker: port-level assertions for the attitude filter, bound to the top.
// Depends on nothing but the top-level port list.
`default_nettype none
module caf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // one item in flight: no accept right after an accept
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item accepted too early");

    // angles stay inside +-360 degree
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) <= 18'sd92160)
            && ($signed(m_axis_tdata[17:0]) >= -18'sd92160)
            && ($signed(m_axis_tdata[35:18]) <= 18'sd92160)
            && ($signed(m_axis_tdata[35:18]) >= -18'sd92160))
        else $error("angle out of range");

    // no output right after an accept from idle output
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too soon");

endmodule

bind complementary_attitude_filter caf_checker u_caf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench for complementary_attitude_filter.
// Drives imu samples on s_axis, predicts fused roll/pitch angles, checks m_axis.
// Depends on caf_pkg and the complementary_attitude_filter rtl.
`default_nettype none
module tb
    import caf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERS = 16;
    localparam int LATENCY = ITERS * 2 + 36;
    localparam logic [15:0] ALPHA_RESET = 16'd64225;

    typedef struct {
        logic signed [15:0] ax, ay, az, g_roll, g_pitch;
        logic [15:0] dt;
    } sensor_item_t;

    typedef struct {
        logic signed [17:0] roll, pitch;
    } attitude_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;

    attitude_t expected_angles[$];
    logic [15:0] alpha_q16 = ALPHA_RESET;
    logic signed [17:0] roll_est = '0;
    logic signed [17:0] pitch_est = '0;

    complementary_attitude_filter #(.CORDIC_ITERATIONS(ITERS)) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),   // accel_x, accel_y, accel_z, gyro_roll, gyro_pitch, dt
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),   // roll_angle, pitch_angle, zero fill
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in 2^-16 degree
    function automatic longint atan2_q16(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = DEG90_Q16;
            end else begin
                t = x; x = -y; y = t; z = -DEG90_Q16;
            end
        end
        for (int i = 0; i < ITERS && i < ATAN_DEPTH; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic logic signed [17:0] blend_angle(logic signed [17:0] est,
            longint rate, longint dt, longint acc_q16);
        longint gyro, mix, r;
        gyro = longint'(est) * 65536 + rate * dt;
        mix = longint'(alpha_q16) * gyro + (65536 - longint'(alpha_q16)) * (acc_q16 * 256);
        r = floor_shr(mix + (longint'(1) <<< 31), 32);
        if (r > 92160) r = 92160;
        if (r < -92160) r = -92160;
        return 18'(r);
    endfunction

    task automatic predict_attitude(sensor_item_t s);
        longint ax, ay, az, mag, roll_tilt, pitch_tilt;
        attitude_t a;
        ax = s.ax; ay = s.ay; az = s.az;
        mag = isqrt((ay * ay + az * az) * 65536);
        roll_tilt = atan2_q16(ay * 256, az * 256);
        pitch_tilt = atan2_q16(-ax * 256, mag);
        roll_est = blend_angle(roll_est, longint'(s.g_roll), longint'(s.dt), roll_tilt);
        pitch_est = blend_angle(pitch_est, longint'(s.g_pitch), longint'(s.dt), pitch_tilt);
        a.roll = roll_est;
        a.pitch = pitch_est;
        expected_angles.push_back(a);
    endtask

    // leaves tvalid high; the next send reloads or idles it, or a drain takes it down
    task automatic send_sample(sensor_item_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s.dt, s.g_pitch, s.g_roll, s.az, s.ay, s.ax};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_attitude(s);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_alpha(logic [15:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        alpha_q16 = v;
    endtask

    function automatic sensor_item_t mk(int ax, int ay, int az, int gr, int gp, int dt);
        sensor_item_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
        s.g_roll = 16'(gr); s.g_pitch = 16'(gp); s.dt = 16'(dt);
        return s;
    endfunction

    function automatic sensor_item_t rand_sample();
        sensor_item_t s;
        // mostly near-level gravity vectors, some full-range noise
        if ($urandom_range(3) != 0) begin
            s = mk($signed(16'($urandom_range(8191))) - 4096,
                   $signed(16'($urandom_range(8191))) - 4096,
                   int'($urandom_range(8191)) - 4096 + ($urandom_range(1) ? 4096 : -4096),
                   int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                   $urandom_range(2000));
        end else begin
            s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
            s.g_roll = 16'($urandom); s.g_pitch = 16'($urandom); s.dt = 16'($urandom);
        end
        return s;
    endfunction

    task automatic test_directed();
        send_sample(mk(0, 0, 0, 0, 0, 0));              // zero vector
        send_sample(mk(0, 0, 4096, 0, 0, 1000));
        send_sample(mk(4096, 0, -4096, 0, 0, 1000));    // negative x operand
        send_sample(mk(-4096, -4096, -4096, 100, -100, 1000));
        send_sample(mk(0, 4096, 0, 0, 0, 0));
        send_sample(mk(0, -4096, 0, 0, 0, 0));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, 65535));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 65535));
        send_sample(mk(0, 32767, -32768, 32767, 32767, 65535));
        send_sample(mk(0, 0, 0, 32767, 32767, 65535));  // drive to saturation
        repeat (4) send_sample(mk(0, 0, 0, 32767, 32767, 65535));
        repeat (6) send_sample(mk(0, 0, 0, -32768, -32768, 65535));
        send_sample(mk(-32768, 0, 0, 0, 0, 0));
    endtask

    task automatic test_alpha_settings();
        logic [15:0] alphas[4] = '{16'd0, 16'd65535, 16'd32768, 16'd1};
        foreach (alphas[k]) begin
            write_alpha(alphas[k]);
            repeat (8) send_sample(rand_sample());
        end
        write_alpha(ALPHA_RESET);
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_sample(rand_sample());
    endtask

    task automatic test_pause_until_drained();
        repeat (5) send_sample(rand_sample());
        wait_drained();
        repeat (5) send_sample(rand_sample());
    endtask

    always @(posedge aclk) begin
        attitude_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_angles.size() == 0) begin
                $error("unexpected item: %h", m_axis_tdata);
                fail_count++;
            end else begin
                e = expected_angles.pop_front();
                if ($signed(m_axis_tdata[17:0]) != e.roll) begin
                    $error("roll_angle expected %0d actual %0d", e.roll,
                           $signed(m_axis_tdata[17:0]));
                    fail_count++;
                end
                if ($signed(m_axis_tdata[35:18]) != e.pitch) begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch,
                           $signed(m_axis_tdata[35:18]));
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_alpha_settings();
        test_random(450, 0, 0);
        test_random(450, 69, 0);
        test_pause_until_drained();
        test_random(450, 0, 69);
        write_alpha(16'd60000);
        test_random(450, 38, 38);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/caf_pkg.sv
hdl/caf_ctrl.sv
hdl/caf_datapath.sv
hdl/complementary_attitude_filter.sv
hdl/caf_checker.sv
verif/tb.sv
